// ----- hw/rtl/fbl_pkg.sv -----
`default_nettype none

package fbl_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned TIW = $clog2(TABLE_ENTRIES);
  localparam logic [31:0] TABLE_ENTRIES_W = 32'(TABLE_ENTRIES);

  localparam int unsigned IDX_W = 12;
  localparam int unsigned CLUS_W = 28;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned BPS_W = 13;
  localparam int unsigned SPC_W = 8;
  localparam int unsigned CB_W = BPS_W + SPC_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CLUS_W-1:0] CHAIN_END = 28'hFFF_FFF8;
  localparam logic [CLUS_W-1:0] FIRST_DATA_CLUSTER = 28'd2;
  localparam int unsigned DIR_ENTRY_SHIFT = 5;

  localparam int unsigned LAM_W = TIW + 2;
  localparam int unsigned DIV_NW = WORD_W;
  localparam int unsigned DIV_DW = (LAM_W > CB_W) ? LAM_W : CB_W;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  localparam int unsigned TABS_W = WORD_W + 2;
  localparam int unsigned FDS_W = 36;
  localparam int unsigned SUM_W = ((FDS_W > TIW + SPC_W) ? FDS_W : TIW + SPC_W) + 1;
  localparam int unsigned FULL_W = SUM_W + BPS_W;

  typedef enum logic {
    OP_LOAD      = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PAST_END  = 2'd1,
    ST_CHAIN_END = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPS    = 3'd0,
    CFG_SPC    = 3'd1,
    CFG_RSV    = 3'd2,
    CFG_COPIES = 3'd3,
    CFG_TSS    = 3'd4,
    CFG_REC    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fbl_ram.sv -----
`default_nettype none

module fbl_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fbl_divider.sv -----
`default_nettype none

module fbl_divider
  import fbl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;

  logic [DIV_DW:0] shifted;
  logic [DIV_DW:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_NW-1]};
    diff    = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DIV_DW]) begin
        rem_d = diff[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fat32_file_byte_locator.sv -----
`default_nettype none
// FAT32 file byte locator.
// Command channel: an item is taken at a rising edge with start high and busy
// low. A load item (op 0) writes one allocation table entry; a translate item
// (op 1) walks the cluster chain of a file and forms the disk byte address.
// Result channel: done_o is high for one cycle with status_o and
// disk_address_o; the receiver cannot stall, so each result beat is taken then.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i; indexes
// beyond the list are dropped. The user must write only while the block is
// idle; the block itself does not enforce it. A load or a translate past
// the file end gives its result in the next cycle and busy stays low. Any
// other translate makes two divisions on the shared bit-serial divider,
// one table read per hop, a further division once to fold a loop when the
// chain loops back on itself, and two address stages.
// One item is in work at a time; busy is high until its result beat.
// Reset clears control state and sets the layout registers to their defaults;
// table contents are undefined until loaded.
module fat32_file_byte_locator
  import fbl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  input  logic [WORD_W-1:0]    entry_value_i,
  input  logic [CLUS_W-1:0]    start_cluster_i,
  input  logic [WORD_W-1:0]    file_length_i,
  input  logic [WORD_W-1:0]    file_offset_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [ADDR_W-1:0]    disk_address_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_HOPS,
    S_WAIT_HOPS,
    S_DIV_FDS,
    S_WAIT_FDS,
    S_CHECK,
    S_HOP,
    S_WAIT_MOD,
    S_ADDR1,
    S_ADDR2
  } state_e;

  logic [BPS_W-1:0]  bps_q;
  logic [SPC_W-1:0]  spc_q;
  logic [15:0]       rsv_q;
  logic [1:0]        copies_q;
  logic [WORD_W-1:0] tss_q;
  logic [15:0]       rec_q;

  state_e            state_q, state_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              skipped_q, skipped_d;

  logic [CLUS_W-1:0] clus_q, clus_d;
  logic [CLUS_W-1:0] saved_q, saved_d;
  logic [LAM_W-1:0]  lam_q, lam_d;
  logic [LAM_W-1:0]  power_q, power_d;
  logic [WORD_W-1:0] foff_q, foff_d;
  logic [WORD_W-1:0] remaining_q, remaining_d;
  logic [CB_W-1:0]   cbytes_q, cbytes_d;
  logic [CB_W-1:0]   rem_off_q, rem_off_d;
  logic [TABS_W-1:0] tabs_q, tabs_d;
  logic [FDS_W-1:0]  fds_q, fds_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  logic [BPS_W-1:0]  bps_eff;
  logic [SPC_W-1:0]  spc_eff;
  logic              accept;
  logic              ram_we;
  logic [CLUS_W-1:0] ram_rdata;
  logic [TIW-1:0]    clus_idx;
  logic [TIW-1:0]    clus_off;
  logic [TIW+SPC_W-1:0] clus_scaled;
  logic [FULL_W-1:0] full_addr;
  logic [21:0]       root_bytes;
  logic              chain_end;
  logic              outside;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign bps_eff = (bps_q == '0) ? BPS_W'(1) : bps_q;
  assign spc_eff = (spc_q == '0) ? SPC_W'(1) : spc_q;
  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign ram_we  = accept && (op_i == OP_LOAD) &&
                   ({{(32-IDX_W){1'b0}}, entry_index_i} < TABLE_ENTRIES_W);

  assign clus_idx    = TIW'(clus_q);
  assign clus_off    = clus_idx - TIW'(FIRST_DATA_CLUSTER);
  assign clus_scaled = (TIW+SPC_W)'(clus_off) * (TIW+SPC_W)'(spc_eff);
  assign full_addr   = FULL_W'(sum_q) * FULL_W'(bps_eff) + FULL_W'(rem_off_q);
  assign root_bytes  = 22'(bps_eff - BPS_W'(1)) + (22'(rec_q) << DIR_ENTRY_SHIFT);
  assign chain_end   = (clus_q >= CHAIN_END);
  assign outside     = (clus_q < FIRST_DATA_CLUSTER) ||
                       ({{(32-CLUS_W){1'b0}}, clus_q} >= TABLE_ENTRIES_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q    <= BPS_W'(512);
      spc_q    <= SPC_W'(8);
      rsv_q    <= 16'd32;
      copies_q <= 2'd2;
      tss_q    <= 32'd1;
      rec_q    <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPS:    bps_q    <= cfg_data_i[BPS_W-1:0];
        CFG_SPC:    spc_q    <= cfg_data_i[SPC_W-1:0];
        CFG_RSV:    rsv_q    <= cfg_data_i[15:0];
        CFG_COPIES: copies_q <= cfg_data_i[1:0];
        CFG_TSS:    tss_q    <= cfg_data_i;
        CFG_REC:    rec_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  fbl_ram #(
    .WIDTH(CLUS_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(TIW'(entry_index_i)),
    .wdata_i(entry_value_i[CLUS_W-1:0]),
    .raddr_i(clus_idx),
    .rdata_o(ram_rdata)
  );

  fbl_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    status_d    = status_q;
    addr_d      = addr_q;
    skipped_d   = skipped_q;
    clus_d      = clus_q;
    saved_d     = saved_q;
    lam_d       = lam_q;
    power_d     = power_q;
    foff_d      = foff_q;
    remaining_d = remaining_q;
    cbytes_d    = cbytes_q;
    rem_off_d   = rem_off_q;
    tabs_d      = tabs_q;
    fds_d       = fds_q;
    sum_d       = sum_q;
    div_req     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          clus_d   = start_cluster_i;
          foff_d   = file_offset_i;
          cbytes_d = CB_W'(bps_eff) * CB_W'(spc_eff);
          tabs_d   = TABS_W'(tss_q) * TABS_W'(copies_q);
          if (op_i == OP_LOAD) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            addr_d   = '0;
          end else if (file_offset_i >= file_length_i) begin
            done_d   = 1'b1;
            status_d = ST_PAST_END;
            addr_d   = '0;
          end else begin
            state_d = S_DIV_HOPS;
          end
        end
      end
      S_DIV_HOPS: begin
        div_req.start    = 1'b1;
        div_req.dividend = foff_q;
        div_req.divisor  = DIV_DW'(cbytes_q);
        state_d          = S_WAIT_HOPS;
      end
      S_WAIT_HOPS: begin
        if (div_rsp.done) begin
          remaining_d = div_rsp.quotient;
          rem_off_d   = CB_W'(div_rsp.remainder);
          state_d     = S_DIV_FDS;
        end
      end
      S_DIV_FDS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NW'(root_bytes);
        div_req.divisor  = DIV_DW'(bps_eff);
        state_d          = S_WAIT_FDS;
      end
      S_WAIT_FDS: begin
        if (div_rsp.done) begin
          fds_d     = FDS_W'(tabs_q) + FDS_W'(rsv_q) + FDS_W'(div_rsp.quotient);
          saved_d   = clus_q;
          lam_d     = '0;
          power_d   = LAM_W'(1);
          skipped_d = 1'b0;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chain_end) begin
          done_d   = 1'b1;
          status_d = ST_CHAIN_END;
          addr_d   = '0;
          state_d  = S_IDLE;
        end else if (outside) begin
          done_d   = 1'b1;
          status_d = ST_OUTSIDE;
          addr_d   = '0;
          state_d  = S_IDLE;
        end else if (remaining_q == '0) begin
          state_d = S_ADDR1;
        end else if (!skipped_q && (lam_q != '0) && (clus_q == saved_q)) begin
          // fold the remaining hops modulo the loop period
          div_req.start    = 1'b1;
          div_req.dividend = remaining_q;
          div_req.divisor  = DIV_DW'(lam_q);
          skipped_d        = 1'b1;
          state_d          = S_WAIT_MOD;
        end else begin
          if (lam_q == power_q) begin
            saved_d = clus_q;
            power_d = power_q << 1;
            lam_d   = LAM_W'(1);
          end else begin
            lam_d = lam_q + LAM_W'(1);
          end
          remaining_d = remaining_q - WORD_W'(1);
          state_d     = S_HOP;
        end
      end
      S_HOP: begin
        clus_d  = ram_rdata;
        state_d = S_CHECK;
      end
      S_WAIT_MOD: begin
        if (div_rsp.done) begin
          remaining_d = WORD_W'(div_rsp.remainder);
          state_d     = S_CHECK;
        end
      end
      S_ADDR1: begin
        sum_d   = SUM_W'(fds_q) + SUM_W'(clus_scaled);
        state_d = S_ADDR2;
      end
      S_ADDR2: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        addr_d   = full_addr[ADDR_W-1:0];
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      addr_q    <= '0;
      skipped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      status_q  <= status_d;
      addr_q    <= addr_d;
      skipped_q <= skipped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clus_q      <= clus_d;
    saved_q     <= saved_d;
    lam_q       <= lam_d;
    power_q     <= power_d;
    foff_q      <= foff_d;
    remaining_q <= remaining_d;
    cbytes_q    <= cbytes_d;
    rem_off_q   <= rem_off_d;
    tabs_q      <= tabs_d;
    fds_q       <= fds_d;
    sum_q       <= sum_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign disk_address_o = addr_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fbl_checker.sv -----
`default_nettype none

module fbl_checker
  import fbl_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 op_i,
  input logic [WORD_W-1:0]    file_length_i,
  input logic [WORD_W-1:0]    file_offset_i,
  input logic                 done_o,
  input logic [1:0]           status_o,
  input logic [ADDR_W-1:0]    disk_address_o
);

  logic accept;
  assign accept = start && !busy;

  load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OP_LOAD) |=>
      done_o && (status_o == ST_OK) && (disk_address_o == '0))
    else $error("load beat did not give an ok result next cycle");

  past_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OP_TRANSLATE) && (file_offset_i >= file_length_i) |=>
      done_o && (status_o == ST_PAST_END))
    else $error("offset past file end not flagged next cycle");

  walk_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == OP_TRANSLATE) && (file_offset_i < file_length_i) |=>
      busy && !done_o)
    else $error("translate walk did not hold busy");

  error_zero_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (disk_address_o == '0))
    else $error("failing result carries an address");

  result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");

endmodule

bind fat32_file_byte_locator fbl_checker u_fbl_checker (.*);

`default_nettype wire

// ----- verif/tb_fat32_file_byte_locator.sv -----
`timescale 1ns / 100ps

module tb_fat32_file_byte_locator;
  import fbl_pkg::*;

  localparam int unsigned WALK_CAP = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
  } location_t;

  class locator_scoreboard;
    bit [CLUS_W-1:0] fat_copy [TABLE_ENTRIES];
    bit              loaded [TABLE_ENTRIES];
    int unsigned     visit_id [TABLE_ENTRIES];
    longint unsigned visit_hop [TABLE_ENTRIES];
    int unsigned     walk_id = 0;
    longint unsigned bps = 512;
    longint unsigned spc = 8;
    longint unsigned rsv = 32;
    longint unsigned copies = 2;
    longint unsigned tss = 1;
    longint unsigned rec = 0;
    location_t       expected_locations[$];
    int unsigned     mismatches = 0;

    function void set_layout_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      case (idx)
        CFG_BPS:    bps = data[BPS_W-1:0];
        CFG_SPC:    spc = data[SPC_W-1:0];
        CFG_RSV:    rsv = data[15:0];
        CFG_COPIES: copies = data[1:0];
        CFG_TSS:    tss = data;
        CFG_REC:    rec = data[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned cluster_bytes();
      return ((bps == 0) ? 1 : bps) * ((spc == 0) ? 1 : spc);
    endfunction

    function void locate(input logic [CLUS_W-1:0] head, input logic [WORD_W-1:0] flen,
                         input logic [WORD_W-1:0] foff, output location_t loc,
                         output bit blind, output int unsigned reads);
      longint unsigned sec, cpc, cbytes, hops, hop, lead, addr;
      logic [CLUS_W-1:0] clus;
      bit folded;
      loc.status = ST_OK;
      loc.addr = '0;
      blind = 0;
      reads = 0;
      if (foff >= flen) begin
        loc.status = ST_PAST_END;
        return;
      end
      sec = (bps == 0) ? 1 : bps;
      cpc = (spc == 0) ? 1 : spc;
      cbytes = sec * cpc;
      hops = foff / cbytes;
      walk_id++;
      clus = head;
      folded = 0;
      hop = 0;
      while (1) begin
        if (clus >= CHAIN_END) begin
          loc.status = ST_CHAIN_END;
          return;
        end
        if (clus < FIRST_DATA_CLUSTER || clus >= TABLE_ENTRIES) begin
          loc.status = ST_OUTSIDE;
          return;
        end
        if (hop == hops) break;
        if (!folded) begin
          if (visit_id[clus[TIW-1:0]] == walk_id) begin
            // fold the remaining hops onto the loop
            hops = hop + (hops - hop) % (hop - visit_hop[clus[TIW-1:0]]);
            folded = 1;
            if (hop == hops) break;
          end else begin
            visit_id[clus[TIW-1:0]] = walk_id;
            visit_hop[clus[TIW-1:0]] = hop;
          end
        end
        if (!loaded[clus[TIW-1:0]]) blind = 1;
        reads++;
        clus = fat_copy[clus[TIW-1:0]];
        hop++;
      end
      lead = copies * tss + rsv + ((sec - 1) + rec * 32) / sec;
      addr = (lead + (clus - 2) * cpc) * sec + foff % cbytes;
      loc.addr = addr[ADDR_W-1:0];
    endfunction

    function bit safe_walk(input logic [CLUS_W-1:0] head, input logic [WORD_W-1:0] flen,
                           input logic [WORD_W-1:0] foff);
      location_t loc;
      bit blind;
      int unsigned reads;
      locate(head, flen, foff, loc, blind, reads);
      return !blind && reads <= WALK_CAP;
    endfunction

    function void note_item(input op_e op, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] val, input logic [CLUS_W-1:0] clus,
                            input logic [WORD_W-1:0] flen, input logic [WORD_W-1:0] foff);
      location_t loc;
      bit blind;
      int unsigned reads;
      if (op == OP_LOAD) begin
        fat_copy[idx] = val[CLUS_W-1:0];
        loaded[idx] = 1;
        loc.status = ST_OK;
        loc.addr = '0;
      end else begin
        locate(clus, flen, foff, loc, blind, reads);
      end
      expected_locations.insert(expected_locations.size(), loc);
    endfunction

    function int unsigned outstanding();
      return expected_locations.size();
    endfunction

    task report_mismatch(input string what);
      $display("ERROR: %s", what);
      mismatches++;
    endtask

    task check_result(input logic [1:0] status, input logic [ADDR_W-1:0] addr);
      location_t want;
      if (expected_locations.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: status %0d address %0h",
                                  status, addr));
        return;
      end
      want = expected_locations.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (addr !== want.addr)
        report_mismatch($sformatf("disk address %0h, expected %0h", addr, want.addr));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 op_i;
  logic [IDX_W-1:0]     entry_index_i;
  logic [WORD_W-1:0]    entry_value_i;
  logic [CLUS_W-1:0]    start_cluster_i;
  logic [WORD_W-1:0]    file_length_i;
  logic [WORD_W-1:0]    file_offset_i;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [ADDR_W-1:0]    disk_address_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  locator_scoreboard ledger = new();
  int unsigned sent = 0;

  fat32_file_byte_locator DUT (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) ledger.check_result(status_o, disk_address_o);
  end

  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] val, input logic [CLUS_W-1:0] clus,
                           input logic [WORD_W-1:0] flen, input logic [WORD_W-1:0] foff);
    @(negedge clk_i);
    op_i = op;
    entry_index_i = idx;
    entry_value_i = val;
    start_cluster_i = clus;
    file_length_i = flen;
    file_offset_i = foff;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ledger.note_item(op, idx, val, clus, flen, foff);
    sent++;
  endtask

  function automatic int unsigned idle_gap(input bit burst);
    int unsigned roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic pause(input int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    start = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (ledger.outstanding() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    ledger.set_layout_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_layout(input logic [WORD_W-1:0] bps, input logic [WORD_W-1:0] spc,
                            input logic [WORD_W-1:0] rsv, input logic [WORD_W-1:0] copies,
                            input logic [WORD_W-1:0] tss, input logic [WORD_W-1:0] rec);
    write_cfg(CFG_BPS, bps);
    write_cfg(CFG_SPC, spc);
    write_cfg(CFG_RSV, rsv);
    write_cfg(CFG_COPIES, copies);
    write_cfg(CFG_TSS, tss);
    write_cfg(CFG_REC, rec);
  endtask

  initial begin
    #1_000_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [CLUS_W-1:0] chain[$];
    logic [CLUS_W-1:0] pick, tail, succ;
    logic [WORD_W-1:0] foff;
    longint unsigned cbytes, hop_n, off, len;
    int unsigned links, goal;
    bit burst, loops, fresh, paused;

    start = 1'b0;
    op_i = 1'b0;
    entry_index_i = '0;
    entry_value_i = '0;
    start_cluster_i = '0;
    file_length_i = '0;
    file_offset_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed beats under the reset layout: 4096-byte clusters
    send_item(OP_LOAD, 12'd2, 32'h0000_0003, '0, '0, '0);
    send_item(OP_LOAD, 12'd3, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(OP_LOAD, 12'd4095, 32'hF000_0002, '0, '0, '0);
    send_item(OP_LOAD, 12'd0, 32'h0FFF_FFF8, '0, '0, '0);
    send_item(OP_LOAD, 12'd100, 32'd100, '0, '0, '0);
    send_item(OP_LOAD, 12'd5, 32'd4096, '0, '0, '0);
    send_item(OP_LOAD, 12'd10, 32'd11, '0, '0, '0);
    send_item(OP_LOAD, 12'd11, 32'd12, '0, '0, '0);
    send_item(OP_LOAD, 12'd12, 32'hA000_000A, '0, '0, '0);
    send_item(OP_TRANSLATE, '0, '0, 28'd4095, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, 28'd4095, 32'hFFFF_FFFF, 32'd4096);
    send_item(OP_TRANSLATE, '0, '0, 28'd4095, 32'hFFFF_FFFF, 32'd8197);
    send_item(OP_TRANSLATE, '0, '0, 28'd4095, 32'hFFFF_FFFF, 32'd12288);
    send_item(OP_TRANSLATE, '0, '0, 28'd2, 32'd0, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, 28'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_TRANSLATE, '0, '0, 28'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(OP_TRANSLATE, '0, '0, 28'd10, 32'hFFFF_FFFF, 32'hFFFF_F123);
    send_item(OP_TRANSLATE, '0, '0, 28'h0FF_FFFF, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, CHAIN_END, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, CHAIN_END - 1, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, 28'd0, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, 28'd1, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, 28'd4096, 32'd1, 32'd0);
    send_item(OP_TRANSLATE, '0, '0, 28'd5, 32'd8192, 32'd4096);
    send_item(OP_TRANSLATE, '0, '0, 28'd3, 32'd4096, 32'd4095);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: begin
          set_layout(512, 1, 32, 2, 1000, 0);
          write_cfg(CFG_SPARE, $urandom);
        end
        1: set_layout(8191, 255, 65535, 3, 32'hFFFF_FFFF, 65535);
        2: set_layout(0, 0, 0, 0, 0, 0);
        3: set_layout(4096, 128, 1, 1, 32'hFFFF_FFFF, 16);
        default: set_layout($urandom_range(0, 1) ? 32'd512 << $urandom_range(0, 3) : $urandom,
                            $urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 7) : $urandom,
                            $urandom, $urandom, $urandom,
                            ($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
      endcase
      goal = sent + 240;
      paused = 0;
      while (sent < goal) begin
        if (!paused && sent + 120 >= goal) begin
          drain();
          paused = 1;
        end
        if ($urandom_range(0, 3) == 0) begin
          pick = $urandom_range(0, 1) ? CLUS_W'($urandom) :
                                       CLUS_W'($urandom_range(0, TABLE_ENTRIES - 1));
          foff = $urandom;
          if ($urandom_range(0, 1)) begin
            send_item(OP_LOAD, IDX_W'($urandom), $urandom, pick, $urandom, foff);
          end else begin
            len = $urandom;
            if (!ledger.safe_walk(pick, len[WORD_W-1:0], foff))
              foff = WORD_W'(foff % ledger.cluster_bytes());
            send_item(OP_TRANSLATE, IDX_W'($urandom), $urandom, pick, len[WORD_W-1:0], foff);
          end
          pause(idle_gap(0));
        end else begin
          chain.delete();
          links = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
          burst = ($urandom_range(0, 4) == 0);
          while (chain.size() < links) begin
            pick = CLUS_W'($urandom_range(FIRST_DATA_CLUSTER, TABLE_ENTRIES - 1));
            fresh = 1;
            foreach (chain[k]) if (chain[k] == pick) fresh = 0;
            if (fresh) chain.insert(chain.size(), pick);
          end
          loops = 0;
          case ($urandom_range(0, 3))
            0: tail = CLUS_W'(CHAIN_END + $urandom_range(0, 7));
            1: begin
              tail = chain[$urandom_range(0, links - 1)];
              loops = 1;
            end
            2: tail = $urandom_range(0, 1) ? CLUS_W'($urandom_range(0, 1)) :
                      CLUS_W'($urandom_range(TABLE_ENTRIES, CHAIN_END - 1));
            default: tail = CLUS_W'($urandom_range(FIRST_DATA_CLUSTER, TABLE_ENTRIES - 1));
          endcase
          foreach (chain[k]) begin
            if (k + 1 < links) succ = chain[k + 1];
            else succ = tail;
            send_item(OP_LOAD, chain[k][IDX_W-1:0], {4'($urandom), succ}, CLUS_W'($urandom),
                      $urandom, $urandom);
            pause(idle_gap(burst));
          end
          repeat ($urandom_range(2, 8)) begin
            cbytes = ledger.cluster_bytes();
            pick = ($urandom_range(0, 2) == 0) ? chain[0] : chain[$urandom_range(0, links - 1)];
            if (loops && $urandom_range(0, 2) == 0) begin
              off = $urandom;
            end else begin
              hop_n = $urandom_range(0, links + 2);
              off = hop_n * cbytes + $urandom_range(0, cbytes - 1);
            end
            if (off > 32'hFFFF_FFFF) off = $urandom;
            case ($urandom_range(0, 9))
              0: len = off;
              1: len = $urandom;
              2: len = off + 1;
              default: len = off + 1 + $urandom;
            endcase
            if (len > 32'hFFFF_FFFF) len = 32'hFFFF_FFFF;
            // hold the walk to loaded entries and a bounded number of hops
            if (!ledger.safe_walk(pick, len[WORD_W-1:0], off[WORD_W-1:0])) off = off % cbytes;
            send_item(OP_TRANSLATE, IDX_W'($urandom), $urandom, pick, len[WORD_W-1:0],
                      off[WORD_W-1:0]);
            pause(idle_gap(burst));
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
